// File: hw/rtl/sha1h_pkg.sv
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types and constants for the SHA-1 message hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] message_byte;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } digest_t;

  // control from the sequencer to the schedule and round units
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_in;
    logic       load_vars;
    logic       round_en;
    logic       fold;
    logic       emit_shift;
    logic [2:0] emit_idx;
  } ctrl_t;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] WORD_LAST  = 3'd4;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    begin
      case (idx)
        3'd0:    v = 32'h67452301;
        3'd1:    v = 32'hEFCDAB89;
        3'd2:    v = 32'h98BADCFE;
        3'd3:    v = 32'h10325476;
        default: v = 32'hC3D2E1F0;
      endcase
      return v;
    end
  endfunction

endpackage

// File: hw/rtl/sha1h_sched.sv
// ----------------------------------------------------------------------------
// sha1h_sched
// 512-bit block window. Collects message bytes, then serves as the rolling
// message schedule: word 0 feeds the round, a new word enters at the bottom.
// ----------------------------------------------------------------------------
module sha1h_sched (
  input  logic             clk,
  input  sha1h_pkg::ctrl_t ctrl,
  output logic [31:0]      w
);
  import sha1h_pkg::*;

  logic [511:0] window;
  logic [31:0]  mix;
  logic [31:0]  w_new;

  // window word k sits at bits [511-32k -: 32]; words 0, 2, 8 and 13 here
  assign mix   = window[511:480] ^ window[447:416] ^ window[255:224] ^ window[95:64];
  assign w_new = {mix[30:0], mix[31]};
  assign w     = window[511:480];

  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      window <= {window[503:0], ctrl.byte_in};
    end else if (ctrl.round_en) begin
      window <= {window[479:0], w_new};
    end
  end

endmodule

// File: hw/rtl/sha1h_round.sv
// ----------------------------------------------------------------------------
// sha1h_round
// Shared SHA-1 round unit: working variables a..e, round counter, and the
// chaining words, which also shift out as the digest.
// ----------------------------------------------------------------------------
module sha1h_round (
  input  logic             clk,
  input  logic             rst,
  input  sha1h_pkg::ctrl_t ctrl,
  input  logic [31:0]      w,
  output logic [31:0]      chain_head,
  output logic             round_last
);
  import sha1h_pkg::*;

  logic [31:0] va, vb, vc, vd, ve;
  logic [31:0] chain [0:4];
  logic [6:0]  cnt;
  logic [31:0] fn;
  logic [31:0] kc;
  logic [31:0] t;

  always_comb begin
    if (cnt < 7'd20) begin
      fn = (vb & vc) | (~vb & vd);
      kc = K0;
    end else if (cnt < 7'd40) begin
      fn = vb ^ vc ^ vd;
      kc = K1;
    end else if (cnt < 7'd60) begin
      fn = (vb & vc) | (vb & vd) | (vc & vd);
      kc = K2;
    end else begin
      fn = vb ^ vc ^ vd;
      kc = K3;
    end
  end

  assign t          = {va[26:0], va[31:27]} + fn + ve + kc + w;
  assign round_last = (cnt == ROUND_LAST);
  assign chain_head = chain[0];

  always_ff @(posedge clk) begin
    if (ctrl.load_vars) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (ctrl.round_en) begin
      ve <= vd;
      vd <= vc;
      vc <= {vb[1:0], vb[31:2]};
      vb <= va;
      va <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load_vars) begin
      cnt <= '0;
    end else if (ctrl.round_en) begin
      cnt <= cnt + 7'd1;
    end
  end

  // on emit the words move toward the head and the initial values refill the
  // tail, so the chain is back at its start value after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= iv_word(3'(i));
      end
    end else if (ctrl.fold) begin
      chain[0] <= chain[0] + va;
      chain[1] <= chain[1] + vb;
      chain[2] <= chain[2] + vc;
      chain[3] <= chain[3] + vd;
      chain[4] <= chain[4] + ve;
    end else if (ctrl.emit_shift) begin
      chain[0] <= chain[1];
      chain[1] <= chain[2];
      chain[2] <= chain[3];
      chain[3] <= chain[4];
      chain[4] <= iv_word(ctrl.emit_idx);
    end
  end

endmodule

// File: hw/rtl/sha1_message_hasher.sv
// ----------------------------------------------------------------------------
// sha1_message_hasher
// SHA-1 over a byte stream, one shared round unit under a small sequencer.
//
//   channel  | direction | handshake                 | payload
//   item     | in        | item_valid / item_stall   | item_t   (byte, end flag)
//   digest   | out       | digest_valid/digest_stall | digest_t (word, index, last)
//
// A byte that does not complete a block or end the message leaves the block
// idle. A byte that completes a block starts 80 rounds in the round unit, then
// one fold. At message end the sequencer shifts in pad and length bytes one a
// cycle (64 - fill, or 128 - fill when an extra block is needed); each full
// block then goes through the rounds and a fold, then five digest words go
// out, one per transfer.
// Reset is synchronous; it restores the initial chain, zero fill and length.
// item_stall is high whenever the block is busy; digest_stall holds the
// current word until it is taken.
// ----------------------------------------------------------------------------
module sha1_message_hasher (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  sha1h_pkg::item_t   item,
  output logic               digest_valid,
  input  logic               digest_stall,
  output sha1h_pkg::digest_t digest
);
  import sha1h_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_FOLD  = 5'b00100,
    S_PAD   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [5:0]  fill, fill_next;
  logic [63:0] message_bits, message_bits_next;
  logic        end_pending, end_pending_next;
  logic        mark_done, mark_done_next;
  logic        len_block, len_block_next;
  logic [2:0]  word_cnt, word_cnt_next;

  ctrl_t       ctrl;
  logic [31:0] w;
  logic [31:0] chain_head;
  logic        round_last;
  logic        item_take;
  logic        digest_take;

  assign item_stall   = (state != S_IDLE);
  assign item_take    = item_valid && !item_stall;
  assign digest_valid = (state == S_EMIT);
  assign digest_take  = digest_valid && !digest_stall;

  assign digest.digest_word = chain_head;
  assign digest.word_number = word_cnt;
  assign digest.final_word  = (word_cnt == WORD_LAST);

  always_comb begin
    state_next        = state;
    fill_next         = fill;
    message_bits_next = message_bits;
    end_pending_next  = end_pending;
    mark_done_next    = mark_done;
    len_block_next    = len_block;
    word_cnt_next     = word_cnt;
    ctrl              = '0;
    ctrl.emit_idx     = word_cnt;

    unique case (state)
      S_IDLE: begin
        if (item_take) begin
          end_pending_next = item.end_of_message;
          if (item.byte_valid) begin
            ctrl.shift_byte   = 1'b1;
            ctrl.byte_in      = item.message_byte;
            fill_next         = fill + 6'd1;
            message_bits_next = message_bits + 64'd8;
            if (fill == 6'd63) begin
              ctrl.load_vars = 1'b1;
              state_next     = S_ROUND;
            end else if (item.end_of_message) begin
              state_next = S_PAD;
            end
          end else if (item.end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_ROUND: begin
        ctrl.round_en = 1'b1;
        if (round_last) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        ctrl.fold = 1'b1;
        if (!end_pending) begin
          state_next = S_IDLE;
        end else if (mark_done && len_block) begin
          state_next = S_EMIT;
        end else begin
          // either the data block filled with the end flag set, or the
          // marker spilled past the length slot and an extra block follows
          if (mark_done) begin
            len_block_next = 1'b1;
          end
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        ctrl.shift_byte = 1'b1;
        fill_next       = fill + 6'd1;
        if (!mark_done) begin
          ctrl.byte_in   = PAD_MARK;
          mark_done_next = 1'b1;
          len_block_next = (fill <= 6'd55);
        end else if (len_block && fill >= 6'd56) begin
          // length goes out big-endian, top byte first
          ctrl.byte_in      = message_bits[63:56];
          message_bits_next = {message_bits[55:0], 8'h00};
        end else begin
          ctrl.byte_in = 8'h00;
        end
        if (fill == 6'd63) begin
          ctrl.load_vars = 1'b1;
          state_next     = S_ROUND;
        end
      end
      S_EMIT: begin
        if (digest_take) begin
          ctrl.emit_shift = 1'b1;
          if (word_cnt == WORD_LAST) begin
            word_cnt_next     = '0;
            fill_next         = '0;
            message_bits_next = '0;
            end_pending_next  = 1'b0;
            mark_done_next    = 1'b0;
            len_block_next    = 1'b0;
            state_next        = S_IDLE;
          end else begin
            word_cnt_next = word_cnt + 3'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      message_bits <= '0;
      end_pending  <= 1'b0;
      mark_done    <= 1'b0;
      len_block    <= 1'b0;
      word_cnt     <= '0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      message_bits <= message_bits_next;
      end_pending  <= end_pending_next;
      mark_done    <= mark_done_next;
      len_block    <= len_block_next;
      word_cnt     <= word_cnt_next;
    end
  end

  sha1h_sched u_sched (
    .clk  (clk),
    .ctrl (ctrl),
    .w    (w)
  );

  sha1h_round u_round (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .w          (w),
    .chain_head (chain_head),
    .round_last (round_last)
  );

  // a block is only compressed once all 64 bytes are in
  a_round_empty_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (fill == 6'd0))
    else $error("round running with partial block fill");

  // fold follows the last round and nothing else
  a_fold_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD) |-> ($past(state) == S_ROUND && $past(round_last)))
    else $error("fold without completed rounds");

  // the length field has been fully shifted out before the digest goes out
  a_emit_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (fill == 6'd0 && message_bits == 64'd0 && mark_done))
    else $error("digest emitted with stale fill or length");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (item_stall && word_cnt <= WORD_LAST))
    else $error("digest word while accepting input or bad index");

endmodule

// File: tb/tb_sha1_message_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_message_hasher
// Streams byte items into the hasher and checks every digest word against a
// built-in SHA-1 model or a stored digest. A short directed table comes first, then random
// messages of many lengths. The sender runs in bursts and the receiver stalls
// on its own pattern, with one long receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb_sha1_message_hasher;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_TARGET  = 460;
  localparam int NUM_DIRECTED = 14;

  localparam logic [159:0] CHAIN_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  localparam logic [159:0] EMPTY_DIGEST =
    160'hDA39A3EE_5E6B4B0D_3255BFEF_95601890_AFD80709;
  localparam logic [31:0] RK0 = 32'h5A827999;
  localparam logic [31:0] RK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RK3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef struct packed {
    logic         byte_valid;
    logic [7:0]   data;
    logic         eom;
    logic         golden;
    logic [159:0] digest;
  } step_row_t;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  sha1h_pkg::item_t    item;
  logic                digest_valid;
  logic                digest_stall;
  sha1h_pkg::digest_t  digest;

  sha1_message_hasher uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // model state
  logic [31:0] chain_h [5];
  logic [7:0]  blk [64];
  int          fill;
  logic [63:0] msg_bits;

  sha1h_pkg::digest_t pending_words [$];
  sha1h_pkg::digest_t got_word;
  sha1h_pkg::digest_t want_word;

  step_row_t dir_rows [NUM_DIRECTED];

  int errors;
  int items_counted;
  int bytes_sent;
  int messages_hashed;
  int words_checked;
  int burst_left;
  int cycle_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR @%0t %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, nw;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        nw = w[(r+13) & 15] ^ w[(r+8) & 15] ^ w[(r+2) & 15] ^ w[r & 15];
        w[r & 15] = {nw[30:0], nw[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d); k = RK0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = RK1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = RK2;
      end else begin
        f = b ^ c ^ d; k = RK3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endfunction

  function automatic void clear_chain();
    for (int i = 0; i < 5; i++)
      chain_h[i] = CHAIN_IV[159-32*i -: 32];
    fill = 0;
    msg_bits = '0;
  endfunction

  // returns 1 and the 160-bit digest when the item closes a message
  function automatic bit absorb_item(input sha1h_pkg::item_t it,
                                     output logic [159:0] dg);
    dg = '0;
    if (it.byte_valid) begin
      blk[fill] = it.message_byte;
      fill++;
      msg_bits += 64'd8;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end
    if (!it.end_of_message)
      return 1'b0;
    blk[fill] = PAD_BYTE;
    fill++;
    // length field no longer fits: spill into an extra block
    if (fill > 56) begin
      while (fill < 64) begin
        blk[fill] = 8'h00;
        fill++;
      end
      compress_block();
      fill = 0;
    end
    while (fill < 56) begin
      blk[fill] = 8'h00;
      fill++;
    end
    for (int i = 0; i < 8; i++)
      blk[56+i] = msg_bits[63-8*i -: 8];
    compress_block();
    dg = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
    clear_chain();
    messages_hashed++;
    return 1'b1;
  endfunction

  function automatic void push_digest(input logic [159:0] dg);
    sha1h_pkg::digest_t w;
    for (int i = 0; i < 5; i++) begin
      w.digest_word = dg[159-32*i -: 32];
      w.word_number = 3'(i);
      w.final_word  = (i == 4);
      pending_words.push_back(w);
    end
  endfunction

  // one transfer on the item channel, then the sender's burst/gap policy
  task automatic drive_item(input logic bv, input logic [7:0] data, input logic eom,
                            input logic golden, input logic [159:0] gold);
    sha1h_pkg::item_t it;
    logic [159:0]     dg;
    int               gap;
    it.byte_valid     = bv;
    it.message_byte   = data;
    it.end_of_message = eom;
    @(negedge clk);
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_counted++;
    if (bv) bytes_sent++;
    if (absorb_item(it, dg))
      push_digest(golden ? gold : dg);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk) item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 8);
    end
  endtask

  // digest channel checker
  always @(posedge clk) begin
    if (!rst && digest_valid && !digest_stall) begin
      got_word = digest;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected digest word", got_word.digest_word, 32'h0);
      end else begin
        want_word = pending_words.pop_front();
        if (got_word.digest_word !== want_word.digest_word)
          report_mismatch("digest_word", got_word.digest_word, want_word.digest_word);
        if (got_word.word_number !== want_word.word_number)
          report_mismatch("word_number", 32'(got_word.word_number),
                          32'(want_word.word_number));
        if (got_word.final_word !== want_word.final_word)
          report_mismatch("final_word", 32'(got_word.final_word),
                          32'(want_word.final_word));
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: randomly chosen stall modes, plus one long hold-off mid-run
  initial begin
    int  mode;
    int  mode_left;
    int  hold_left;
    bit  hold_done;
    digest_stall = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_counted >= 200) begin
        hold_left = 500;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        digest_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0: digest_stall <= 1'b0;
          1: digest_stall <= 1'($urandom_range(0, 1));
          2: digest_stall <= (mode_left % 4 == 0);
          default: digest_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin
    int   len;
    int   pick;
    int   random_msgs;
    bit   tail_sep;
    logic eom;
    errors = 0;
    items_counted = 0;
    bytes_sent = 0;
    messages_hashed = 0;
    words_checked = 0;
    burst_left = 0;
    cycle_count = 0;
    random_msgs = 0;
    item_valid = 1'b0;
    item = '0;
    rst = 1'b1;
    clear_chain();

    // directed: empty messages, ignored bytes, single-byte extremes, "abc"
    dir_rows[0]  = {1'b0, 8'h00, 1'b1, 1'b1, EMPTY_DIGEST};
    dir_rows[1]  = {1'b0, 8'hA5, 1'b0, 1'b0, 160'h0};
    dir_rows[2]  = {1'b0, 8'h5A, 1'b1, 1'b1, EMPTY_DIGEST};
    dir_rows[3]  = {1'b1, 8'h00, 1'b1, 1'b0, 160'h0};
    dir_rows[4]  = {1'b1, 8'hFF, 1'b1, 1'b0, 160'h0};
    dir_rows[5]  = {1'b1, 8'h61, 1'b0, 1'b0, 160'h0};
    dir_rows[6]  = {1'b1, 8'h62, 1'b0, 1'b0, 160'h0};
    dir_rows[7]  = {1'b1, 8'h63, 1'b1, 1'b0, 160'h0};
    dir_rows[8]  = {1'b1, 8'hFF, 1'b0, 1'b0, 160'h0};
    dir_rows[9]  = {1'b0, 8'hFF, 1'b1, 1'b0, 160'h0};
    dir_rows[10] = {1'b1, 8'h80, 1'b0, 1'b0, 160'h0};
    dir_rows[11] = {1'b1, 8'h7F, 1'b0, 1'b0, 160'h0};
    dir_rows[12] = {1'b0, 8'hFF, 1'b0, 1'b0, 160'h0};
    dir_rows[13] = {1'b1, 8'h01, 1'b1, 1'b0, 160'h0};

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int r = 0; r < NUM_DIRECTED; r++)
      drive_item(dir_rows[r].byte_valid, dir_rows[r].data, dir_rows[r].eom,
                 dir_rows[r].golden, dir_rows[r].digest);

    // random messages; lengths bunch around the padding and block boundaries
    while (items_counted < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 11)
        len = $urandom_range(0, 20);
      else if (pick < 16)
        len = $urandom_range(21, 70);
      else begin
        case ($urandom_range(0, 9))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          7: len = 120;
          8: len = 127;
          default: len = 128;
        endcase
      end
      tail_sep = (len == 0) || ($urandom_range(0, 1) == 1);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 9) == 0)
          drive_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 160'h0);
        eom = !tail_sep && (j == len - 1);
        drive_item(1'b1, 8'($urandom_range(0, 255)), eom, 1'b0, 160'h0);
      end
      if (tail_sep)
        drive_item(1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 160'h0);
      random_msgs++;
      // one full drain with the sender quiet
      if (random_msgs == 4) begin
        @(negedge clk) item_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
      end
    end

    @(negedge clk) item_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Hashed %0d messages from %0d byte transfers; %0d digest words compared",
             messages_hashed, bytes_sent, words_checked);
    $display("Lengths spanned empty to two full blocks, under burst/stall traffic");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sha1h_pkg.sv
hw/rtl/sha1h_sched.sv
hw/rtl/sha1h_round.sv
hw/rtl/sha1_message_hasher.sv
tb/tb_sha1_message_hasher.sv
